>>> rtl/core/aas_pkg.sv
// Shared types and constants for the autoencoder anomaly scorer.
// No dependencies.
package aas_pkg;

  localparam int unsigned DATA_W = 16;  // Q4.12 data words
  localparam int unsigned FRAC_W = 12;  // fraction bits of Q4.12
  localparam int unsigned PROD_W = 32;  // Q8.24 product or shifted bias
  localparam int unsigned ACC_W  = 40;  // saturating accumulator
  localparam int unsigned SCORE_W = 32; // Q8.24 error score
  localparam int unsigned ADDR_W = 11;  // weight_address field width

  // Input item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Configuration register indexes
  localparam logic REG_THRESHOLD = 1'b0;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

endpackage

>>> rtl/core/autoencoder_anomaly_scorer.sv
// Autoencoder anomaly scorer top level: weight store, activation buffers,
// MAC sequencer and error scoring. Depends on aas_pkg and aas_div.
//
// Usage: the input channel carries load items (kind 0) that write one
// weight or bias word into the weight store, and sample items (kind 1)
// that supply one sample element each. The element flagged last starts an
// inference; the block then stalls its input until the result is done.
// The network runs on one MAC fed by a single-port weight store with a
// registered read, one read per cycle: one per weight and one per output
// bias, 1429 reads for the default sizes. Each layer adds a setup state
// (S_START) and a pipeline drain (S_DRAIN), the last layer's drain also
// covering the difference, square and sum stages; then the divide by
// OUT_DIM runs. Load items and non-final sample elements do not stall.
// The result (error_score, anomaly) sits in an output register; while the
// receiver stalls, new items are still accepted, and a finished inference
// waits for the slot to free. Reset clears the control state, the element
// counter and the threshold; weight store and buffers are undefined until
// written. The user must write the threshold register over the APB port
// only while idle; the block itself does not enforce this.
module autoencoder_anomaly_scorer
  import aas_pkg::*;
#(
  parameter int unsigned IN_DIM       = 5,
  parameter int unsigned HIDDEN_DIM   = 32,
  parameter int unsigned EMB_DIM      = 16,
  parameter int unsigned OUT_DIM      = 5,
  parameter int unsigned WEIGHT_DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     kind_i,
  input  logic [ADDR_W-1:0]        weight_address_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     last_element_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [SCORE_W-1:0]       error_score_o,
  output logic                     anomaly_o,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int unsigned AW   = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
  localparam int unsigned MAXD = (IN_DIM > HIDDEN_DIM ? IN_DIM : HIDDEN_DIM) >
                                 (EMB_DIM > OUT_DIM ? EMB_DIM : OUT_DIM) ?
                                 (IN_DIM > HIDDEN_DIM ? IN_DIM : HIDDEN_DIM) :
                                 (EMB_DIM > OUT_DIM ? EMB_DIM : OUT_DIM);
  localparam int unsigned CW   = $clog2(MAXD + 1);
  localparam int unsigned SW   = (IN_DIM > 1) ? $clog2(IN_DIM) : 1;
  localparam int unsigned HW   = (HIDDEN_DIM > 1) ? $clog2(HIDDEN_DIM) : 1;
  localparam int unsigned EW   = (EMB_DIM > 1) ? $clog2(EMB_DIM) : 1;
  localparam int unsigned ECW  = $clog2(IN_DIM + 1);
  localparam int unsigned SUM_W = SCORE_W + $clog2(OUT_DIM + 1) + 1;

  // Offset from a layer's first weight to its first bias, modulo the store
  localparam int unsigned OFF0 = (IN_DIM * HIDDEN_DIM) % WEIGHT_DEPTH;
  localparam int unsigned OFF1 = (HIDDEN_DIM * EMB_DIM) % WEIGHT_DEPTH;
  localparam int unsigned OFF2 = (EMB_DIM * HIDDEN_DIM) % WEIGHT_DEPTH;
  localparam int unsigned OFF3 = (HIDDEN_DIM * OUT_DIM) % WEIGHT_DEPTH;

  typedef enum logic [1:0] {L_ENC1, L_ENC2, L_DEC1, L_DEC2} layer_e;
  typedef enum logic [2:0] {S_IDLE, S_START, S_ISSUE, S_DRAIN, S_DIVIDE, S_HOLD} state_e;

  // Storage
  logic signed [DATA_W-1:0] wmem [WEIGHT_DEPTH];
  logic signed [DATA_W-1:0] hid_mem [HIDDEN_DIM];
  logic signed [DATA_W-1:0] emb_mem [EMB_DIM];
  logic signed [DATA_W-1:0] sample_q [IN_DIM];
  logic [ECW-1:0]           elem_cnt_q;
  logic [SCORE_W-1:0]       thr_q;

  // Sequencer
  state_e         state_q;
  layer_e         layer_q;
  logic [AW-1:0]  wptr_q, bptr_q;
  logic [CW-1:0]  i_q, j_q;
  logic           bias_ph_q;
  logic [CW-1:0]  n_in_m1, n_out_m1;
  logic [AW:0]    off_c;
  logic [AW:0]    bsum;

  // Pipeline
  logic                     v1_q, bias1_q, last1_q;
  logic [CW-1:0]            j1_q;
  logic signed [DATA_W-1:0] w_rd_q, a_rd_q;
  logic                     v2_q, last2_q;
  logic [CW-1:0]            j2_q;
  logic signed [PROD_W-1:0] term2_q;
  logic                     bias2_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     done3_q;
  logic [CW-1:0]            j3_q;
  logic                     dv_q, sv_q;
  logic signed [DATA_W:0]   d_q;
  logic [SCORE_W-1:0]       sq_q;
  logic [SUM_W-1:0]         sum_q;
  logic                     anom_q;

  // Output register
  logic                     out_valid_q;
  logic [SCORE_W-1:0]       score_q;
  logic                     anomaly_q;

  logic in_acc, slot_free, issue, wrd_en, pipe_busy, res_load;
  logic [AW-1:0] rd_addr;
  logic div_start, div_done;
  logic [SUM_W-1:0] quot;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign issue     = (state_q == S_ISSUE);
  assign pipe_busy = v1_q || v2_q || done3_q || dv_q || sv_q;
  assign res_load  = ((state_q == S_DIVIDE && div_done) || state_q == S_HOLD) && slot_free;

  // Per-layer dimensions
  always_comb begin
    case (layer_q)
      L_ENC1: begin
        n_in_m1 = CW'(IN_DIM - 1); n_out_m1 = CW'(HIDDEN_DIM - 1);
        off_c = (AW+1)'(OFF0);
      end
      L_ENC2: begin
        n_in_m1 = CW'(HIDDEN_DIM - 1); n_out_m1 = CW'(EMB_DIM - 1);
        off_c = (AW+1)'(OFF1);
      end
      L_DEC1: begin
        n_in_m1 = CW'(EMB_DIM - 1); n_out_m1 = CW'(HIDDEN_DIM - 1);
        off_c = (AW+1)'(OFF2);
      end
      default: begin
        n_in_m1 = CW'(HIDDEN_DIM - 1); n_out_m1 = CW'(OUT_DIM - 1);
        off_c = (AW+1)'(OFF3);
      end
    endcase
  end

  // Bias base = layer base + weight count, wrapped into the store
  always_comb begin
    bsum = {1'b0, wptr_q} + off_c;
    if (bsum >= (AW+1)'(WEIGHT_DEPTH)) bsum = bsum - (AW+1)'(WEIGHT_DEPTH);
  end

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(WEIGHT_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign rd_addr = bias_ph_q ? bptr_q : wptr_q;
  assign wrd_en  = in_acc && (kind_i == KIND_LOAD) &&
                   ({6'd0, weight_address_i} < 17'(WEIGHT_DEPTH));

  // Weight store, single port
  always_ff @(posedge clk_i) begin
    if (wrd_en) begin
      wmem[AW'(weight_address_i)] <= value_i;
    end else if (issue) begin
      w_rd_q <= wmem[rd_addr];
    end
  end

  // Sequencer and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      layer_q    <= L_ENC1;
      elem_cnt_q <= '0;
      thr_q      <= '0;
      wptr_q     <= '0;
      bptr_q     <= '0;
      i_q        <= '0;
      j_q        <= '0;
      bias_ph_q  <= 1'b1;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      done3_q    <= 1'b0;
      dv_q       <= 1'b0;
      sv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && (paddr[2] == REG_THRESHOLD)) thr_q <= pwdata;
      if (res_load) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;

      // pipeline valid bits
      v1_q    <= issue;
      v2_q    <= v1_q;
      done3_q <= v2_q && last2_q;
      dv_q    <= done3_q && (layer_q == L_DEC2);
      sv_q    <= dv_q;

      case (state_q)
        S_IDLE: begin
          if (in_acc && (kind_i == KIND_SAMPLE)) begin
            if (last_element_i) begin
              elem_cnt_q <= '0;
              layer_q    <= L_ENC1;
              wptr_q     <= '0;
              state_q    <= S_START;
            end else if (elem_cnt_q < ECW'(IN_DIM)) begin
              elem_cnt_q <= elem_cnt_q + ECW'(1);
            end
          end
        end
        S_START: begin
          bptr_q    <= bsum[AW-1:0];
          i_q       <= '0;
          j_q       <= '0;
          bias_ph_q <= 1'b1;
          state_q   <= S_ISSUE;
        end
        S_ISSUE: begin
          if (bias_ph_q) begin
            bptr_q    <= wrap_inc(bptr_q);
            bias_ph_q <= 1'b0;
          end else begin
            wptr_q <= wrap_inc(wptr_q);
            if (i_q == n_in_m1) begin
              i_q       <= '0;
              bias_ph_q <= 1'b1;
              j_q       <= j_q + CW'(1);
              if (j_q == n_out_m1) state_q <= S_DRAIN;
            end else begin
              i_q <= i_q + CW'(1);
            end
          end
        end
        S_DRAIN: begin
          if (!pipe_busy) begin
            wptr_q <= bptr_q;
            if (layer_q == L_DEC2) begin
              state_q <= S_DIVIDE;
            end else begin
              layer_q <= layer_e'(layer_q + 2'd1);
              state_q <= S_START;
            end
          end
        end
        S_DIVIDE: begin
          if (div_done) begin
            if (slot_free) begin
              state_q <= S_IDLE;
            end else begin
              state_q <= S_HOLD;
            end
          end
        end
        S_HOLD: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Issue tags travel with the weight read
  always_ff @(posedge clk_i) begin
    bias1_q <= bias_ph_q;
    last1_q <= !bias_ph_q && (i_q == n_in_m1);
    j1_q    <= j_q;
    j2_q    <= j1_q;
    last2_q <= last1_q;
    bias2_q <= bias1_q;
    j3_q    <= j2_q;
  end

  // Sample buffer and activation buffers; activation read alongside weight
  logic signed [ACC_W:0]   rnd;
  logic signed [DATA_W-1:0] r4, r4_relu;

  // Round to Q4.12 with saturation
  always_comb begin
    rnd = (ACC_W+1)'(acc_q) + (ACC_W+1)'(2048);
    rnd = rnd >>> FRAC_W;
    if (rnd > (ACC_W+1)'(32767)) r4 = 16'sh7FFF;
    else if (rnd < -(ACC_W+1)'(32768)) r4 = 16'sh8000;
    else r4 = rnd[DATA_W-1:0];
    r4_relu = r4[DATA_W-1] ? '0 : r4;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (kind_i == KIND_SAMPLE) && (elem_cnt_q < ECW'(IN_DIM)))
      sample_q[elem_cnt_q[SW-1:0]] <= value_i;
    if (issue) begin
      case (layer_q)
        L_ENC1:  a_rd_q <= sample_q[i_q[SW-1:0]];
        L_DEC1:  a_rd_q <= emb_mem[i_q[EW-1:0]];
        default: a_rd_q <= hid_mem[i_q[HW-1:0]];
      endcase
    end
    if (done3_q) begin
      case (layer_q)
        L_ENC1, L_DEC1: hid_mem[j3_q[HW-1:0]] <= r4_relu;
        L_ENC2:         emb_mem[j3_q[EW-1:0]] <= r4_relu;
        default: begin
          if (j3_q < CW'(IN_DIM))
            d_q <= (DATA_W+1)'(sample_q[j3_q[SW-1:0]]) - (DATA_W+1)'(r4);
          else
            d_q <= -(DATA_W+1)'(r4);
        end
      endcase
    end
  end

  // MAC datapath: product, then saturating accumulate
  logic signed [ACC_W:0] acc_sum;
  assign acc_sum = (ACC_W+1)'(acc_q) + (ACC_W+1)'(term2_q);

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      if (bias1_q) term2_q <= PROD_W'(w_rd_q) <<< FRAC_W;
      else         term2_q <= w_rd_q * a_rd_q;
    end
    if (v2_q) begin
      if (bias2_q) acc_q <= ACC_W'(term2_q);
      else if (acc_sum > (ACC_W+1)'(ACC_MAX)) acc_q <= ACC_MAX;
      else if (acc_sum < (ACC_W+1)'(ACC_MIN)) acc_q <= ACC_MIN;
      else acc_q <= acc_sum[ACC_W-1:0];
    end
    // squared difference and running sum
    if (dv_q) sq_q <= SCORE_W'(d_q) * SCORE_W'(d_q);
    if (state_q == S_START && layer_q == L_ENC1) sum_q <= '0;
    else if (sv_q) sum_q <= sum_q + SUM_W'(sq_q);
    if (div_start) anom_q <= (sum_q > SUM_W'(thr_q) * SUM_W'(OUT_DIM));
  end

  assign div_start = (state_q == S_DRAIN) && !pipe_busy && (layer_q == L_DEC2);

  aas_div #(
    .NUM_W   (SUM_W),
    .DIVISOR (OUT_DIM)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sum_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      score_q   <= (quot > SUM_W'({SCORE_W{1'b1}})) ? {SCORE_W{1'b1}} : quot[SCORE_W-1:0];
      anomaly_q <= anom_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign error_score_o = score_q;
  assign anomaly_o     = anomaly_q;
  assign pready        = 1'b1;
  assign prdata        = (paddr[2] == REG_THRESHOLD) ? thr_q : '0;

endmodule

>>> rtl/core/aas_div.sv
// Divider by a constant through reciprocal multiplication, in registered steps.
// Depends on no package.
module aas_div #(
  parameter int unsigned NUM_W   = 36,
  parameter int unsigned DIVISOR = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  // quot = (num * ceil(2^SHIFT / DIVISOR)) >> SHIFT, exact for num < 2^NUM_W
  localparam int unsigned SH_W  = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
  localparam int unsigned SHIFT = NUM_W + SH_W;
  localparam int unsigned M_W   = NUM_W + 1;
  localparam int unsigned LO_W  = (M_W + 1) / 2;
  localparam int unsigned HI_W  = M_W - LO_W;
  localparam int unsigned P_W   = NUM_W + M_W;
  localparam logic [63:0] RECIP =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [LO_W-1:0] RECIP_LO = RECIP[LO_W-1:0];
  localparam logic [HI_W-1:0] RECIP_HI = HI_W'(RECIP >> LO_W);

  logic [NUM_W-1:0]      num_q;
  logic [NUM_W+LO_W-1:0] plo;
  logic [NUM_W+HI_W-1:0] phi;
  logic [NUM_W+LO_W-1:0] lo_q;
  logic [P_W-1:0]        prod_q;
  logic                  s1_q, s2_q, done_q;

  // Two partial products against the halves of the reciprocal
  assign plo = num_q * RECIP_LO;
  assign phi = num_q * RECIP_HI;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= start_i;
      s2_q   <= s1_q;
      done_q <= s2_q;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) num_q <= num_i;
    if (s1_q) lo_q <= plo;
    if (s2_q) prod_q <= {phi, {LO_W{1'b0}}} + P_W'(lo_q);
  end

  assign done_o = done_q;
  assign quot_o = NUM_W'(prod_q >> SHIFT);

endmodule
